// ===== hw/rtl/mask_password_from_index_assert.svh =====
// Assertion macros for the password mask generator.
// Each macro expands to one labelled concurrent assertion, clocked on clk_i
// and disabled while rst_ni is low.
`ifndef MASK_PASSWORD_FROM_INDEX_ASSERT_SVH
`define MASK_PASSWORD_FROM_INDEX_ASSERT_SVH

// Same-cycle implication
`define MPFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MPFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpfi_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfi_pkg
// Shared types, constants and character tables of the password mask generator.
// ----------------------------------------------------------------------------
package mpfi_pkg;

  // Sizes
  localparam int unsigned MAX_LEN   = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned IDX_W     = 64;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned REM_W     = 6;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LENGTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_CLASSES = 1'b1;

  // Character classes
  typedef enum logic [1:0] {
    CLS_ALNUM = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_LOWER = 2'd2,
    CLS_UPPER = 2'd3
  } mpfi_class_e;

  // Control from the sequencer to the serial divider
  typedef struct packed {
    logic        load;
    logic        start;
    mpfi_class_e cls;
  } mpfi_div_ctrl_t;

  // Status back from the divider
  typedef struct packed {
    logic busy;
    logic done;
  } mpfi_div_sts_t;

  // Radix of a class
  function automatic logic [REM_W:0] class_size(mpfi_class_e cls);
    logic [REM_W:0] sz;
    case (cls)
      CLS_ALNUM: sz = 7'd62;
      CLS_DIGIT: sz = 7'd10;
      default:   sz = 7'd26;
    endcase
    return sz;
  endfunction

  // ASCII code of digit idx within a class
  function automatic logic [CHAR_W-1:0] char_of(mpfi_class_e cls, logic [REM_W-1:0] idx);
    logic [CHAR_W-1:0] i8;
    logic [CHAR_W-1:0] ch;
    i8 = {2'b00, idx};
    case (cls)
      CLS_ALNUM: begin
        if (i8 < 8'd26) begin
          ch = 8'h61 + i8;
        end else if (i8 < 8'd52) begin
          ch = 8'h41 + (i8 - 8'd26);
        end else begin
          ch = 8'h30 + (i8 - 8'd52);
        end
      end
      CLS_DIGIT: ch = 8'h30 + i8;
      CLS_LOWER: ch = 8'h61 + i8;
      default:   ch = 8'h41 + i8;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/mask_password_from_index.sv =====
// ----------------------------------------------------------------------------
// mask_password_from_index
// Turns a 64-bit candidate index into one password, one character per result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one candidate index per
//   request. Output channel (out_valid_o / out_ready_i) returns one character
//   per password position, last position first; last_o marks position 0.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i:
//   index 0 is the mask length, index 1 the two-bit class of each position.
//   Each position is one pass of a bit-serial divider over the 64-bit
//   running index, after which the digit is handed to the output register.
//   in_ready_o rises once the last character sits in the output register,
//   so the next index starts while that one waits.
//   When the receiver stalls, the finished digit waits in the divider and the
//   next pass starts as soon as the output register is taken.
//   Reset clears the sequencer and the output register; the mask length
//   returns to one position and all positions to the alphanumeric class.
// ----------------------------------------------------------------------------
module mask_password_from_index (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] candidate_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic [3:0]  position_o,
  output logic        last_o
);
  import mpfi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e               state_q;
  logic [LEN_W-1:0]     mask_len_q;
  logic [CFG_DAT_W-1:0] classes_q;
  logic [POS_W-1:0]     pos_q;
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic [POS_W-1:0]     out_pos_q;
  logic                 last_q;

  logic [LEN_W-1:0]     len_eff;
  logic [POS_W-1:0]     pos_first;
  logic [POS_W-1:0]     pos_next;
  mpfi_class_e          cls_cur;
  mpfi_class_e          cls_first;
  mpfi_class_e          cls_next;
  logic                 in_req;
  logic                 digit_ready;
  logic                 out_free;
  logic                 emit;
  mpfi_div_ctrl_t       div_ctrl;
  mpfi_div_sts_t        div_sts;
  logic [REM_W-1:0]     div_rem;

  // Saturate the mask length to 1..MAX_LEN
  always_comb begin
    len_eff = mask_len_q;
    if (mask_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (mask_len_q > LEN_W'(MAX_LEN)) begin
      len_eff = LEN_W'(MAX_LEN);
    end
  end

  assign pos_first = POS_W'(len_eff - LEN_W'(1));
  assign pos_next  = pos_q - POS_W'(1);
  assign cls_cur   = mpfi_class_e'(classes_q[2*pos_q +: 2]);
  assign cls_first = mpfi_class_e'(classes_q[2*pos_first +: 2]);
  assign cls_next  = mpfi_class_e'(classes_q[2*pos_next +: 2]);

  // Handshake and digit hand-over
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_req      = in_valid_i && in_ready_o;
  assign digit_ready = ((state_q == ST_DIV) && div_sts.done) || (state_q == ST_HOLD);
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = digit_ready && out_free;

  // Divider control
  always_comb begin
    div_ctrl.load  = in_req;
    div_ctrl.start = 1'b0;
    div_ctrl.cls   = cls_first;
    if (in_req) begin
      div_ctrl.start = 1'b1;
    end else if (emit && (pos_q != '0)) begin
      div_ctrl.start = 1'b1;
      div_ctrl.cls   = cls_next;
    end
  end

  mpfi_serdiv u_serdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (candidate_index_i),
    .sts_o      (div_sts),
    .rem_o      (div_rem)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_len_q <= LEN_W'(1);
      classes_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MASK_LENGTH:      mask_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_POSITION_CLASSES: classes_q  <= cfg_data_i;
        default:              ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new character enters the register, else a taken character empties it
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            pos_q   <= pos_first;
            state_q <= ST_DIV;
          end
        end
        ST_DIV, ST_HOLD: begin
          if (emit) begin
            if (pos_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q   <= pos_next;
              state_q <= ST_DIV;
            end
          end else if (digit_ready) begin
            state_q <= ST_HOLD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q    <= char_of(cls_cur, div_rem);
      out_pos_q <= pos_q;
      last_q    <= (pos_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign position_o  = out_pos_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/mpfi_serdiv.sv =====
// ----------------------------------------------------------------------------
// mpfi_serdiv
// Bit-serial restoring divider of the 64-bit running index by a class radix.
// ----------------------------------------------------------------------------
module mpfi_serdiv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mpfi_pkg::mpfi_div_ctrl_t ctrl_i,
  input  logic [63:0]             dividend_i,
  output mpfi_pkg::mpfi_div_sts_t  sts_o,
  output logic [5:0]              rem_o
);
  import mpfi_pkg::*;

  logic [IDX_W-1:0] val_q, val_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  mpfi_class_e      cls_q, cls_d;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   size;
  logic             ge;
  logic [REM_W:0]   diff;

  // One quotient bit per cycle: bring down the top bit of the running value
  assign size  = class_size(cls_q);
  assign trial = {rem_q, val_q[IDX_W-1]};
  assign ge    = (trial >= size);
  assign diff  = trial - size;

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cls_d  = cls_q;
    if (busy_q) begin
      val_d = {val_q[IDX_W-2:0], ge};
      rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == {CNT_W{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    // new index enters the shift register
    if (ctrl_i.load) begin
      val_d = dividend_i;
    end
    // next digit: quotient of the last pass is already in place
    if (ctrl_i.start) begin
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      cls_d  = ctrl_i.cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    cls_q <= cls_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

// ===== hw/rtl/mpfi_checker.sv =====
// ----------------------------------------------------------------------------
// mpfi_checker
// Port-level checks of the password mask generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "mask_password_from_index_assert.svh"

module mpfi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  character_o,
  input logic [3:0]  position_o,
  input logic        last_o
);

  // A taken request keeps the block busy in the next cycle
  `MPFI_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready after request")

  // While a character other than the last is shown, more remain to come
  `MPFI_ASSERT_NOW(a_busy_mid_item, out_valid_o && !last_o, !in_ready_o, "idle mid password")

  // The last flag marks exactly position zero
  `MPFI_ASSERT_NOW(a_last_pos, out_valid_o, last_o == (position_o == 4'd0), "last flag mismatch")

  // A stalled result holds
  `MPFI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(character_o) && $stable(position_o), "result dropped")

endmodule

bind mask_password_from_index mpfi_checker u_mpfi_checker (.*);
